### rtl/core/su3lp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package su3lp_pkg;

  localparam int FracBitsDef   = 30;
  localparam int LineCntBitsDef = 20;
  localparam int ElemW  = 32;
  localparam int PartW  = 40;
  localparam int TraceW = 33;
  localparam int Lanes  = 3;

  localparam logic [1:0] RowLast = 2'd2;
  localparam logic [1:0] RowNone = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_TRACE,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       mul_en;
    logic       acc_en;
    logic       set_ident;
    logic [1:0] row;
  } lane_ctl_t;

  function automatic logic signed [PartW-1:0] sat_part(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd1 <<< (PartW - 1);
    lo = -hi;
    hi = hi - 64'sd1;
    if (v > hi) return hi[PartW-1:0];
    else if (v < lo) return lo[PartW-1:0];
    else return v[PartW-1:0];
  endfunction

  function automatic logic signed [ElemW-1:0] sat_elem(input logic signed [PartW-1:0] v);
    logic signed [PartW-1:0] hi;
    logic signed [PartW-1:0] lo;
    hi = PartW'(64'sd1 <<< (ElemW - 1)) - PartW'(1);
    lo = -hi - PartW'(1);
    if (v > hi) return hi[ElemW-1:0];
    else if (v < lo) return lo[ElemW-1:0];
    else return v[ElemW-1:0];
  endfunction

  function automatic logic signed [TraceW-1:0] sat_trace(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd1 <<< (TraceW - 1);
    lo = -hi;
    hi = hi - 64'sd1;
    if (v > hi) return hi[TraceW-1:0];
    else if (v < lo) return lo[TraceW-1:0];
    else return v[TraceW-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/su3lp_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module su3lp_lane
  import su3lp_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef,
  parameter int LANE_IDX  = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lane_ctl_t               ctl,
  input  wire logic signed [ElemW-1:0] u_re [Lanes],
  input  wire logic signed [ElemW-1:0] u_im [Lanes],
  output logic signed [ElemW-1:0]      diag_re,
  output logic signed [ElemW-1:0]      diag_im
);

  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [ElemW-1:0] One = ElemW'(64'sd1 <<< FRAC_BITS);

  logic signed [ElemW-1:0] path_re_r [Lanes];
  logic signed [ElemW-1:0] path_im_r [Lanes];
  logic signed [PartW-1:0] part_re_r [Lanes];
  logic signed [PartW-1:0] part_im_r [Lanes];
  logic signed [PartW-1:0] part_re_nxt [Lanes];
  logic signed [PartW-1:0] part_im_nxt [Lanes];
  logic signed [63:0] prr_r [Lanes];
  logic signed [63:0] pii_r [Lanes];
  logic signed [63:0] pri_r [Lanes];
  logic signed [63:0] pir_r [Lanes];
  logic signed [ElemW-1:0] cre;
  logic signed [ElemW-1:0] cim;

  // column of the running product picked by the row number
  always_comb begin
    case (ctl.row)
      2'd0: begin
        cre = path_re_r[0];
        cim = path_im_r[0];
      end
      2'd1: begin
        cre = path_re_r[1];
        cim = path_im_r[1];
      end
      default: begin
        cre = path_re_r[2];
        cim = path_im_r[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      for (int j = 0; j < Lanes; j++) begin
        prr_r[j] <= 64'(cre) * 64'(u_re[j]);
        pii_r[j] <= 64'(cim) * 64'(u_im[j]);
        pri_r[j] <= 64'(cre) * 64'(u_im[j]);
        pir_r[j] <= 64'(cim) * 64'(u_re[j]);
      end
    end
  end

  always_comb begin
    logic signed [63:0] t_re;
    logic signed [63:0] t_im;
    logic signed [PartW-1:0] s_re;
    logic signed [PartW-1:0] s_im;
    for (int j = 0; j < Lanes; j++) begin
      t_re = ((prr_r[j] + Half) >>> FRAC_BITS) - ((pii_r[j] + Half) >>> FRAC_BITS);
      t_im = ((pri_r[j] + Half) >>> FRAC_BITS) + ((pir_r[j] + Half) >>> FRAC_BITS);
      s_re = sat_part(t_re);
      s_im = sat_part(t_im);
      part_re_nxt[j] = sat_part(64'(part_re_r[j]) + 64'(s_re));
      part_im_nxt[j] = sat_part(64'(part_im_r[j]) + 64'(s_im));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.set_ident) begin
      for (int j = 0; j < Lanes; j++) begin
        path_re_r[j] <= (j == LANE_IDX) ? One : '0;
        path_im_r[j] <= '0;
      end
    end else if (ctl.acc_en && ctl.row == RowLast) begin
      for (int j = 0; j < Lanes; j++) begin
        path_re_r[j] <= sat_elem(part_re_nxt[j]);
        path_im_r[j] <= sat_elem(part_im_nxt[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < Lanes; j++) begin
        part_re_r[j] <= '0;
        part_im_r[j] <= '0;
      end
    end else if (ctl.acc_en) begin
      for (int j = 0; j < Lanes; j++) begin
        part_re_r[j] <= (ctl.row == RowLast) ? '0 : part_re_nxt[j];
        part_im_r[j] <= (ctl.row == RowLast) ? '0 : part_im_nxt[j];
      end
    end
  end

  assign diag_re = path_re_r[LANE_IDX];
  assign diag_im = path_im_r[LANE_IDX];

endmodule
`default_nettype wire

### rtl/core/su3lp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module su3lp_div
  import su3lp_pkg::*;
#(
  parameter int DW = 54,
  parameter int VW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CW = $clog2(DW);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic          fits;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### rtl/core/su3lp_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module su3lp_merge
  import su3lp_pkg::*;
#(
  parameter int LINE_COUNT_BITS = LineCntBitsDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     trace_en,
  input  wire logic                     eod,
  input  wire logic signed [ElemW-1:0]  diag_re [Lanes],
  input  wire logic signed [ElemW-1:0]  diag_im [Lanes],
  output logic                          done,
  output logic signed [TraceW-1:0]      trace_re,
  output logic signed [TraceW-1:0]      trace_im,
  output logic signed [TraceW-1:0]      avg_re,
  output logic signed [TraceW-1:0]      avg_im,
  output logic                          avg_valid
);

  localparam int SumW = TraceW + LINE_COUNT_BITS + 1;
  localparam int CntW = LINE_COUNT_BITS + 1;
  localparam logic [CntW-1:0] CntMax = CntW'(1) << LINE_COUNT_BITS;

  logic signed [SumW-1:0] sum_re_r, sum_im_r, sum_re_new, sum_im_new;
  logic [CntW-1:0] cnt_r, cnt_new;
  logic signed [TraceW-1:0] tr_re, tr_im;
  logic signed [TraceW-1:0] trace_re_r, trace_im_r, avg_re_r, avg_im_r;
  logic avg_valid_r, done_r, neg_re_r, neg_im_r, div_start;
  logic [SumW-1:0] mag_re, mag_im, q_re, q_im;
  logic div_done_re, div_done_im;

  function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW:0] v);
    logic signed [SumW:0] hi;
    logic signed [SumW:0] lo;
    hi = (SumW + 1)'(1) <<< (SumW - 1);
    lo = -hi;
    hi = hi - (SumW + 1)'(1);
    if (v > hi) return hi[SumW-1:0];
    else if (v < lo) return lo[SumW-1:0];
    else return v[SumW-1:0];
  endfunction

  always_comb begin
    tr_re = sat_trace(64'(diag_re[0]) + 64'(diag_re[1]) + 64'(diag_re[2]));
    tr_im = sat_trace(64'(diag_im[0]) + 64'(diag_im[1]) + 64'(diag_im[2]));
    sum_re_new = sat_sum((SumW + 1)'(sum_re_r) + (SumW + 1)'(tr_re));
    sum_im_new = sat_sum((SumW + 1)'(sum_im_r) + (SumW + 1)'(tr_im));
    cnt_new = (cnt_r == CntMax) ? cnt_r : cnt_r + CntW'(1);
    // round half away from zero: add half the count to the magnitude
    mag_re = (sum_re_new < 0 ? SumW'(-sum_re_new) : SumW'(sum_re_new))
             + SumW'(cnt_new >> 1);
    mag_im = (sum_im_new < 0 ? SumW'(-sum_im_new) : SumW'(sum_im_new))
             + SumW'(cnt_new >> 1);
    div_start = trace_en && eod;
  end

  su3lp_div #(.DW(SumW), .VW(CntW)) u_div_re (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mag_re),
    .divisor(cnt_new), .done(div_done_re), .quotient(q_re)
  );

  su3lp_div #(.DW(SumW), .VW(CntW)) u_div_im (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mag_im),
    .divisor(cnt_new), .done(div_done_im), .quotient(q_im)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_re_r    <= '0;
      sum_im_r    <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      avg_valid_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (trace_en) begin
        trace_re_r <= tr_re;
        trace_im_r <= tr_im;
        neg_re_r   <= sum_re_new < 0;
        neg_im_r   <= sum_im_new < 0;
        if (eod) begin
          sum_re_r <= '0;
          sum_im_r <= '0;
          cnt_r    <= '0;
        end else begin
          sum_re_r    <= sum_re_new;
          sum_im_r    <= sum_im_new;
          cnt_r       <= cnt_new;
          avg_re_r    <= '0;
          avg_im_r    <= '0;
          avg_valid_r <= 1'b0;
          done_r      <= 1'b1;
        end
      end else if (div_done_re && div_done_im) begin
        avg_re_r <= sat_trace(neg_re_r ? -64'(q_re) : 64'(q_re));
        avg_im_r <= sat_trace(neg_im_r ? -64'(q_im) : 64'(q_im));
        avg_valid_r <= 1'b1;
        done_r      <= 1'b1;
      end
    end
  end

  assign done      = done_r;
  assign trace_re  = trace_re_r;
  assign trace_im  = trace_im_r;
  assign avg_re    = avg_re_r;
  assign avg_im    = avg_im_r;
  assign avg_valid = avg_valid_r;

endmodule
`default_nettype wire

### rtl/core/su3_line_product_trace_average_core.sv
// steps: a row 0 or 1 word is multiplied, then accumulated, before the next word can be accepted
// a row 2 word does the same; when it closes a line the trace and sums follow, plus the
// divide steps and mean register when it also closes a direction, then the emit step
// a new word is accepted only once the last has finished all its steps (in_ready in idle)
// reset (synchronous, rst_n low): product set to identity, partial sums, trace sums, count cleared
`timescale 1ns / 1ps
`default_nettype none
module su3_line_product_trace_average_core
  import su3lp_pkg::*;
#(
  parameter int FRAC_BITS       = FracBitsDef,
  parameter int LINE_COUNT_BITS = LineCntBitsDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [ElemW-1:0]  in_elem0_re,
  input  wire logic signed [ElemW-1:0]  in_elem0_im,
  input  wire logic signed [ElemW-1:0]  in_elem1_re,
  input  wire logic signed [ElemW-1:0]  in_elem1_im,
  input  wire logic signed [ElemW-1:0]  in_elem2_re,
  input  wire logic signed [ElemW-1:0]  in_elem2_im,
  input  wire logic [1:0]               in_row_index,
  input  wire logic                     in_end_of_line,
  input  wire logic                     in_end_of_direction,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [TraceW-1:0]      out_trace_re,
  output logic signed [TraceW-1:0]      out_trace_im,
  output logic signed [TraceW-1:0]      out_average_re,
  output logic signed [TraceW-1:0]      out_average_im,
  output logic                          out_average_valid
);

  state_t state_r, state_nxt;
  lane_ctl_t ctl;

  // latched word
  logic signed [ElemW-1:0] u_re_r [Lanes];
  logic signed [ElemW-1:0] u_im_r [Lanes];
  logic [1:0] row_r;
  logic eol_r, eod_r;
  logic in_acc;

  logic signed [ElemW-1:0] diag_re [Lanes];
  logic signed [ElemW-1:0] diag_im [Lanes];

  logic merge_done, trace_en, out_load;
  logic signed [TraceW-1:0] m_tr_re, m_tr_im, m_avg_re, m_avg_im;
  logic m_avg_valid;

  // output register, keeps the result while new words come in
  logic out_valid_r;
  logic signed [TraceW-1:0] out_tr_re_r, out_tr_im_r, out_avg_re_r, out_avg_im_r;
  logic out_avg_valid_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      u_re_r[0] <= in_elem0_re;
      u_im_r[0] <= in_elem0_im;
      u_re_r[1] <= in_elem1_re;
      u_im_r[1] <= in_elem1_im;
      u_re_r[2] <= in_elem2_re;
      u_im_r[2] <= in_elem2_im;
      row_r     <= in_row_index;
      eol_r     <= in_end_of_line;
      eod_r     <= in_end_of_direction;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer: multiply, accumulate, then on a line end trace, divide on a direction end, and emit
  always_comb begin
    state_nxt     = state_r;
    ctl.mul_en    = 1'b0;
    ctl.acc_en    = 1'b0;
    ctl.set_ident = 1'b0;
    ctl.row       = row_r;
    trace_en      = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // row three words are dropped
        if (in_acc && in_row_index != RowNone) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc_en = 1'b1;
        state_nxt  = (row_r == RowLast && eol_r) ? ST_TRACE : ST_IDLE;
      end
      ST_TRACE: begin
        trace_en      = 1'b1;
        ctl.set_ident = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (merge_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    su3lp_lane #(.FRAC_BITS(FRAC_BITS), .LANE_IDX(g)) u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .u_re(u_re_r), .u_im(u_im_r),
      .diag_re(diag_re[g]), .diag_im(diag_im[g])
    );
  end

  su3lp_merge #(.LINE_COUNT_BITS(LINE_COUNT_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .trace_en(trace_en), .eod(eod_r),
    .diag_re(diag_re), .diag_im(diag_im), .done(merge_done),
    .trace_re(m_tr_re), .trace_im(m_tr_im), .avg_re(m_avg_re), .avg_im(m_avg_im),
    .avg_valid(m_avg_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tr_re_r     <= m_tr_re;
      out_tr_im_r     <= m_tr_im;
      out_avg_re_r    <= m_avg_re;
      out_avg_im_r    <= m_avg_im;
      out_avg_valid_r <= m_avg_valid;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trace_re      = out_tr_re_r;
  assign out_trace_im      = out_tr_im_r;
  assign out_average_re    = out_avg_re_r;
  assign out_average_im    = out_avg_im_r;
  assign out_average_valid = out_avg_valid_r;

  // a dropped row three word leaves the block ready
  a_row3_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_row_index == RowNone |=> in_ready)
    else $error("row three word started work");

  // mean is zero unless flagged
  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_average_valid |-> out_average_re == '0 && out_average_im == '0)
    else $error("average fields set without a direction end");

  // a new result only follows the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> state_r == ST_EMIT && $past(state_r) != ST_IDLE)
    else $error("result loaded outside emit");

endmodule
`default_nettype wire
